// ===== hdl/pthe_pkg.sv =====
package pthe_pkg;

    // characters that get special handling
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_AMP    = 8'h26;

    localparam int THRESH_W     = 16;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 16'd5000;

    localparam int IDX_W = 5;

    localparam int P_LEN       = 3;
    localparam int BR_LEN      = 4;
    localparam int FN_OPEN_LEN = 30;
    localparam int FN_CLOSE_LEN = 17;
    localparam int LT_LEN      = 4;
    localparam int GT_LEN      = 4;
    localparam int AMP_LEN     = 5;
    localparam int WBR_LEN     = 5;

    localparam logic [8*P_LEN-1:0]        P_STR        = "<P>";
    localparam logic [8*BR_LEN-1:0]       BR_STR       = "<BR>";
    localparam logic [8*FN_OPEN_LEN-1:0]  FN_OPEN_STR  = "<FONT COLOR=\"#80000\"><SMALL> (";
    localparam logic [8*FN_CLOSE_LEN-1:0] FN_CLOSE_STR = ") </SMALL></FONT>";
    localparam logic [8*LT_LEN-1:0]       LT_STR       = "&lt;";
    localparam logic [8*GT_LEN-1:0]       GT_STR       = "&gt;";
    localparam logic [8*AMP_LEN-1:0]      AMP_STR      = "&amp;";
    localparam logic [8*WBR_LEN-1:0]      WBR_STR      = "<WBR>";

    // command queue between classifier and expander
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);

    typedef enum logic [3:0] {
        OP_PASS,
        OP_P,
        OP_BR,
        OP_FN_OPEN,
        OP_FN_CLOSE,
        OP_LT,
        OP_GT,
        OP_AMP,
        OP_WBR
    } t_op;

    typedef struct packed {
        logic       br;     // emit <BR> before the main run
        t_op        op;
        logic [7:0] data;
        logic       eot;
    } t_cmd;

    function automatic logic [IDX_W-1:0] op_len(input t_op op);
        logic [IDX_W-1:0] len;
        case (op)
            OP_P:        len = IDX_W'(P_LEN);
            OP_BR:       len = IDX_W'(BR_LEN);
            OP_FN_OPEN:  len = IDX_W'(FN_OPEN_LEN);
            OP_FN_CLOSE: len = IDX_W'(FN_CLOSE_LEN);
            OP_LT:       len = IDX_W'(LT_LEN);
            OP_GT:       len = IDX_W'(GT_LEN);
            OP_AMP:      len = IDX_W'(AMP_LEN);
            OP_WBR:      len = IDX_W'(WBR_LEN);
            default:     len = IDX_W'(1);
        endcase
        return len;
    endfunction

    function automatic logic [7:0] op_byte(input t_op op, input logic [IDX_W-1:0] idx,
                                           input logic [7:0] data);
        logic [7:0] b;
        case (op)
            OP_P:        b = P_STR[8*(P_LEN-1-int'(idx)) +: 8];
            OP_BR:       b = BR_STR[8*(BR_LEN-1-int'(idx)) +: 8];
            OP_FN_OPEN:  b = FN_OPEN_STR[8*(FN_OPEN_LEN-1-int'(idx)) +: 8];
            OP_FN_CLOSE: b = FN_CLOSE_STR[8*(FN_CLOSE_LEN-1-int'(idx)) +: 8];
            OP_LT:       b = LT_STR[8*(LT_LEN-1-int'(idx)) +: 8];
            OP_GT:       b = GT_STR[8*(GT_LEN-1-int'(idx)) +: 8];
            OP_AMP:      b = AMP_STR[8*(AMP_LEN-1-int'(idx)) +: 8];
            OP_WBR:      b = WBR_STR[8*(WBR_LEN-1-int'(idx)) +: 8];
            default:     b = data;
        endcase
        return b;
    endfunction

endpackage

// ===== hdl/pthe_front.sv =====
module pthe_front #(
    parameter int COUNT_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [7:0]                     i_in_byte,
    input  logic                           i_end_of_text,
    input  logic [pthe_pkg::THRESH_W-1:0]  i_threshold,
    input  logic                           i_full,
    output logic                           o_push,
    output pthe_pkg::t_cmd                 o_cmd
);
    import pthe_pkg::*;

    localparam int CMP_W = (COUNT_BITS > THRESH_W) ? COUNT_BITS : THRESH_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic                  r_held, n_held;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  accept;
    logic                  push;
    logic                  over;
    t_cmd                  cmd;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;
    assign over    = CMP_W'(r_count) > CMP_W'(i_threshold);

    always_comb begin
        n_held   = r_held;
        n_count  = r_count;
        push     = 1'b0;
        cmd.br   = 1'b0;
        cmd.op   = OP_PASS;
        cmd.data = i_in_byte;
        cmd.eot  = i_end_of_text;
        if (i_in_byte == CH_NL) begin
            if (r_held) begin
                cmd.op = OP_P;
                push   = 1'b1;
                n_held = 1'b0;
            end else if (i_end_of_text) begin
                cmd.op = OP_BR;
                push   = 1'b1;
            end else begin
                // lone newline waits for the next beat
                n_held = 1'b1;
            end
        end else begin
            cmd.br = r_held;
            n_held = 1'b0;
            push   = 1'b1;
            case (i_in_byte)
                CH_LBRACE: cmd.op = OP_FN_OPEN;
                CH_RBRACE: cmd.op = OP_FN_CLOSE;
                CH_LT:     cmd.op = OP_LT;
                CH_GT:     cmd.op = OP_GT;
                CH_AMP:    cmd.op = OP_AMP;
                default: begin
                    if (i_in_byte == CH_SPACE && over) begin
                        cmd.op  = OP_WBR;
                        n_count = '0;
                    end else if (r_count != COUNT_MAX) begin
                        n_count = r_count + 1'b1;
                    end
                end
            endcase
        end
        if (i_end_of_text) begin
            n_held  = 1'b0;
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= 1'b0;
            r_count <= '0;
        end else if (accept) begin
            r_held  <= n_held;
            r_count <= n_count;
        end
    end

    assign o_push = accept && push;
    assign o_cmd  = cmd;

endmodule

// ===== hdl/pthe_cmd_fifo.sv =====
module pthe_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pthe_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output pthe_pkg::t_cmd o_head
);
    import pthe_pkg::*;

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr, r_rd;
    logic [CMD_PTR_W:0]   r_cnt, n_cnt;
    logic                 do_pop;

    assign o_full  = r_cnt == (CMD_PTR_W+1)'(CMD_DEPTH);
    assign o_empty = r_cnt == '0;
    assign do_pop  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && do_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

// ===== hdl/pthe_back.sv =====
module pthe_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  pthe_pkg::t_cmd i_head,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_out_byte,
    output logic           o_run_last,
    output logic           o_text_done
);
    import pthe_pkg::*;

    logic             r_in_main;
    logic [IDX_W-1:0] r_idx;
    logic             r_o_valid;
    logic [7:0]       r_out_byte;
    logic             r_run_last;
    logic             r_text_done;

    logic             emit;
    logic             in_pre;
    t_op              seg_op;
    logic             seg_end;
    logic             cmd_end;
    logic [7:0]       cur_byte;

    // the prefix <BR> runs first, then the command's own string
    assign in_pre   = i_head.br && !r_in_main;
    assign seg_op   = in_pre ? OP_BR : i_head.op;
    assign seg_end  = r_idx == op_len(seg_op) - 1'b1;
    assign cmd_end  = seg_end && !in_pre;
    assign cur_byte = op_byte(seg_op, r_idx, i_head.data);
    assign emit     = !i_empty && (!r_o_valid || i_ready);
    assign o_pop    = emit && cmd_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_main <= 1'b0;
            r_idx     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_o_valid <= 1'b1;
                if (seg_end) begin
                    r_idx     <= '0;
                    r_in_main <= in_pre;
                end else begin
                    r_idx <= r_idx + 1'b1;
                end
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte  <= cur_byte;
            r_run_last  <= cmd_end;
            r_text_done <= cmd_end && i_head.eot;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_out_byte  = r_out_byte;
    assign o_run_last  = r_run_last;
    assign o_text_done = r_text_done;

endmodule

// ===== hdl/plain_text_to_html_escaper.sv =====
// plain text to html escaper
//
// input channel: i_valid/o_ready with i_in_byte and i_end_of_text, one text byte
// per beat. output channel: o_valid/i_ready with o_out_byte, o_run_last (last
// byte caused by one input beat) and o_text_done (last byte of an end-of-text
// beat). config channel: i_cfg_valid/o_cfg_ready with i_cfg_wrap_threshold,
// always ready; the user must have it written only while the block is idle;
// the block itself does not enforce this. an accepted beat is classified at
// once and stored as a command in a 4-entry queue; the expander reads the
// queue head and sends one byte per cycle while the receiver is ready,
// through an output register, so the first byte of a beat passes the queue
// and then the output register. throughput: one input beat per cycle while
// each beat makes one byte and the receiver is ready; a longer beat holds the
// single output byte path, so input rate follows its byte count (up to 34 bytes).
// a lone newline makes no byte until the next beat decides <P> or <BR>.
// when the receiver stalls the output register holds, the queue fills and
// o_ready drops. synchronous active-low reset empties the queue, clears the
// held newline and the pass counter, and sets the threshold to 5000.
module plain_text_to_html_escaper #(
    parameter int COUNT_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [7:0]                    i_in_byte,
    input  logic                          i_end_of_text,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [7:0]                    o_out_byte,
    output logic                          o_run_last,
    output logic                          o_text_done,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pthe_pkg::THRESH_W-1:0] i_cfg_wrap_threshold
);
    import pthe_pkg::*;

    logic [THRESH_W-1:0] r_threshold;
    logic                push;
    logic                pop;
    logic                full;
    logic                empty;
    t_cmd                push_cmd;
    t_cmd                head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESH_RESET;
        end else if (i_cfg_valid) begin
            r_threshold <= i_cfg_wrap_threshold;
        end
    end

    pthe_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_in_byte     (i_in_byte),
        .i_end_of_text (i_end_of_text),
        .i_threshold   (r_threshold),
        .i_full        (full),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    pthe_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    pthe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (empty),
        .i_head      (head),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_byte  (o_out_byte),
        .o_run_last  (o_run_last),
        .o_text_done (o_text_done)
    );

endmodule

// ===== hdl/pthe_checker.sv =====
module pthe_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_out_byte,
    input logic       o_run_last,
    input logic       o_text_done
);

    // a stalled output beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_out_byte)
            && $stable(o_run_last) && $stable(o_text_done))
        else $error("output beat changed while stalled");

    // text end only ever closes a run
    a_done_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_text_done |-> o_run_last)
        else $error("text_done without run_last");

    // reset empties the output side
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid right after reset");

    // a beat can only show up after some input was taken
    a_no_spurious: assert property (@(posedge i_clk)
        !i_rst_n ##1 !(i_valid && o_ready) |=> !o_valid)
        else $error("output beat without any input");

endmodule

bind plain_text_to_html_escaper pthe_checker u_pthe_checker (.*);
